// ===== hdl/hvd_pkg.sv =====
// Shared types, codes and score arithmetic for the HMM Viterbi decoder.
// Depends on nothing; every other file of the block but hvd_ram imports it.
`default_nettype none

package hvd_pkg;

	localparam int SCORE_W = 24;

	typedef logic signed [SCORE_W-1:0] score_t;

	// The most negative score stands for minus infinity.
	localparam score_t SCORE_FLOOR = 24'sh800000;
	localparam score_t SCORE_CEIL  = 24'sh7FFFFF;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_EMIT   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_ORDER = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;
	localparam logic [1:0] ERR_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] from_state;
		logic [2:0] to_state;
		score_t     log_value;
	} item_t;

	typedef struct packed {
		logic [2:0] state_index;
		logic [5:0] time_index;
		score_t     best_score;
		logic       last;
		logic [1:0] error_code;
	} result_t;

	typedef struct packed {
		logic clear;
		logic en;
	} acs_ctl_t;

	// Saturating add; a floor operand makes the sum the floor.
	function automatic score_t sat_add(score_t a, score_t b);
		logic signed [SCORE_W:0] s;
		score_t r;
		s = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
		if (a == SCORE_FLOOR || b == SCORE_FLOOR) begin
			r = SCORE_FLOOR;
		end else if (s[SCORE_W] != s[SCORE_W-1]) begin
			r = s[SCORE_W] ? SCORE_FLOOR : SCORE_CEIL;
		end else begin
			r = s[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module hvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/hvd_acs.sv =====
// Shared add-compare-select unit: one saturating add and one compare per cycle,
// keeping the running best score and its index. Depends on hvd_pkg.
`default_nettype none

module hvd_acs import hvd_pkg::*; #(
	parameter int NUM_STATES = 8,
	localparam int SW = $clog2(NUM_STATES)
) (
	input  logic          clk,
	input  acs_ctl_t      ctl,
	input  score_t        a,
	input  score_t        b,
	input  logic [SW-1:0] idx,
	output score_t        best,
	output logic [SW-1:0] ptr
);

	score_t cand;

	assign cand = sat_add(a, b);

	// Only a strictly greater candidate replaces the best, so ties keep the lowest index.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			best <= SCORE_FLOOR;
			ptr  <= '0;
		end else if (ctl.en && cand > best) begin
			best <= cand;
			ptr  <= idx;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hmm_viterbi_decoder_core.sv =====
// Log-domain HMM Viterbi decoder. A transition load leaves the core idle and ready. An
// emission item runs through ST_ACS, where the shared add-compare-select unit handles
// one predecessor per cycle behind the registered read of the transition RAM, then ST_UPD
// stores the score and the backpointer. A finish item scans the final scores in ST_MAX to
// find the best final state, then alternates ST_TB_OUT and ST_TB_RD (the backpointer RAM
// read) per decoded state, from the last time step down to time 0; an output stall holds
// ST_TB_OUT. Error results pass through ST_ERR. There is no clearing pass.
// Depends on hvd_pkg, hvd_ram and hvd_acs.
`default_nettype none

module hmm_viterbi_decoder_core import hvd_pkg::*; #(
	parameter int NUM_STATES = 8,
	parameter int MAX_STEPS  = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int SW     = $clog2(NUM_STATES);
	localparam int NS_P2  = 2 ** SW;
	localparam int KW     = $clog2(NUM_STATES + 1);
	localparam int TW     = $clog2(MAX_STEPS);
	localparam int TCW    = $clog2(MAX_STEPS + 1);
	localparam int TBL_AW = 2 * SW;
	localparam int BP_AW  = TW + SW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ACS    = 3'd1;
	localparam logic [2:0] ST_UPD    = 3'd2;
	localparam logic [2:0] ST_MAX    = 3'd3;
	localparam logic [2:0] ST_TB_OUT = 3'd4;
	localparam logic [2:0] ST_TB_RD  = 3'd5;
	localparam logic [2:0] ST_ERR    = 3'd6;

	logic [2:0]     state_q;
	logic [KW-1:0]  k_q;
	logic [SW-1:0]  to_q;
	score_t         val_q;
	logic [1:0]     err_q;
	logic [SW-1:0]  exp_q;
	logic [TCW-1:0] tc_q;
	logic [SW-1:0]  st_q;
	logic [TW-1:0]  t_q;
	score_t         prev_q [NS_P2];
	score_t         cur_q  [NS_P2];
	result_t        result_q;
	logic           result_valid_q;

	logic          accept;
	logic          out_free;
	logic          seq_full;
	logic          order_bad;
	logic          load_ok;
	logic          restart;
	logic          step_end;
	logic          res_load;
	result_t       res_next;
	logic [SW-1:0] acs_idx;
	score_t        acs_b;
	acs_ctl_t      acs_ctl;
	score_t        acs_best;
	logic [SW-1:0] acs_ptr;
	score_t        new_score;
	logic          tbl_we;
	score_t        tbl_rdata;
	logic          bp_we;
	logic [SW-1:0] bp_rdata;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign seq_full  = (tc_q == TCW'(MAX_STEPS));
	assign order_bad = ({5'd0, item.to_state} != 8'(exp_q));
	assign load_ok   = ({5'd0, item.from_state} < 8'(NUM_STATES)) &&
	                   ({5'd0, item.to_state} < 8'(NUM_STATES));
	assign step_end  = (exp_q == SW'(NUM_STATES - 1));
	assign new_score = sat_add(acs_best, val_q);

	assign restart = (accept && item.command == CMD_FINISH && tc_q == '0) ||
	                 (state_q == ST_TB_OUT && out_free && t_q == '0);

	// During the add-compare-select the registered RAM data matches the previous count, so the index is k_q minus one.
	always_comb begin
		acs_idx = SW'(k_q);
		acs_b   = '0;
		if (state_q == ST_ACS) begin
			acs_idx = SW'(k_q - KW'(1));
			acs_b   = tbl_rdata;
		end
	end

	assign acs_ctl.clear = accept;
	assign acs_ctl.en    = (state_q == ST_ACS && k_q != '0) ||
	                       (state_q == ST_MAX && k_q < KW'(NUM_STATES));

	hvd_acs #(
		.NUM_STATES(NUM_STATES)
	) u_acs (
		.clk (clk),
		.ctl (acs_ctl),
		.a   (prev_q[acs_idx]),
		.b   (acs_b),
		.idx (acs_idx),
		.best(acs_best),
		.ptr (acs_ptr)
	);

	assign tbl_we = accept && item.command == CMD_LOAD && load_ok;

	hvd_ram #(
		.WIDTH(SCORE_W),
		.DEPTH(2 ** TBL_AW)
	) u_tbl_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr({SW'(item.from_state), SW'(item.to_state)}),
		.wdata(item.log_value),
		.raddr({k_q[SW-1:0], to_q}),
		.rdata(tbl_rdata)
	);

	assign bp_we = (state_q == ST_UPD);

	hvd_ram #(
		.WIDTH(SW),
		.DEPTH(2 ** BP_AW)
	) u_bp_ram (
		.clk  (clk),
		.we   (bp_we),
		.waddr({tc_q[TW-1:0], to_q}),
		.wdata(acs_ptr),
		.raddr({t_q, st_q}),
		.rdata(bp_rdata)
	);

	always_comb begin
		res_load = 1'b0;
		res_next = '0;
		if (state_q == ST_ERR && out_free) begin
			res_load            = 1'b1;
			res_next.last       = 1'b1;
			res_next.error_code = err_q;
		end else if (state_q == ST_TB_OUT && out_free) begin
			res_load             = 1'b1;
			res_next.state_index = 3'(st_q);
			res_next.time_index  = 6'(t_q);
			res_next.best_score  = acs_best;
			res_next.last        = (t_q == '0);
			res_next.error_code  = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						case (item.command)
							CMD_EMIT: begin
								state_q <= (seq_full || order_bad) ? ST_ERR : ST_ACS;
							end
							CMD_FINISH: begin
								state_q <= (tc_q == '0) ? ST_ERR : ST_MAX;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ACS: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(NUM_STATES)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				ST_MAX: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(NUM_STATES)) begin
						state_q <= ST_TB_OUT;
					end
				end
				ST_TB_OUT: begin
					if (out_free) begin
						state_q <= (t_q == '0) ? ST_IDLE : ST_TB_RD;
					end
				end
				ST_TB_RD: begin
					state_q <= ST_TB_OUT;
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Path scores and sequence position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS_P2; j++) begin
				prev_q[j] <= (j == 0) ? '0 : SCORE_FLOOR;
				cur_q[j]  <= SCORE_FLOOR;
			end
			tc_q  <= '0;
			exp_q <= '0;
		end else if (restart) begin
			for (int j = 0; j < NS_P2; j++) begin
				prev_q[j] <= (j == 0) ? '0 : SCORE_FLOOR;
				cur_q[j]  <= SCORE_FLOOR;
			end
			tc_q  <= '0;
			exp_q <= '0;
		end else if (state_q == ST_UPD) begin
			if (step_end) begin
				// The last state of a step closes it: the new scores become the previous ones.
				for (int j = 0; j < NS_P2; j++) begin
					prev_q[j] <= (SW'(j) == to_q) ? new_score : cur_q[j];
					cur_q[j]  <= SCORE_FLOOR;
				end
				exp_q <= '0;
				tc_q  <= tc_q + TCW'(1);
			end else begin
				cur_q[to_q] <= new_score;
				exp_q       <= exp_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			to_q  <= SW'(item.to_state);
			val_q <= item.log_value;
			if (item.command == CMD_FINISH) begin
				err_q <= ERR_EMPTY;
			end else if (seq_full) begin
				err_q <= ERR_FULL;
			end else begin
				err_q <= ERR_ORDER;
			end
		end
		if (state_q == ST_MAX && k_q == KW'(NUM_STATES)) begin
			st_q <= acs_ptr;
			t_q  <= TW'(tc_q - TCW'(1));
		end else if (state_q == ST_TB_RD) begin
			st_q <= bp_rdata;
			t_q  <= t_q - TW'(1);
		end
		if (res_load) begin
			result_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hvd_checker.sv =====
// Port-level checks for the HMM Viterbi decoder, bound to the top level.
// Depends on hvd_pkg and hmm_viterbi_decoder_core.
`default_nettype none

module hvd_checker import hvd_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// A stalled result item holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	// Error results end their run and carry zero payload.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_code != ERR_OK |->
		result.last && result.state_index == 3'd0 && result.time_index == 6'd0 &&
		result.best_score == '0)
		else $error("malformed error result");

	// A transition load finishes in the cycle it is accepted.
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.command == CMD_LOAD |=> item_ready)
		else $error("not ready after a transition load");

	// An accepted emission or finish leaves the core busy, in the shared unit or in the error state.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready &&
		(item.command == CMD_EMIT || item.command == CMD_FINISH) |=> !item_ready)
		else $error("ready right after an emission or finish");

endmodule

bind hmm_viterbi_decoder_core hvd_checker u_hvd_checker (.*);

`default_nettype wire

// ===== tb/tb_hmm_viterbi_decoder_core.sv =====
// Self-checking testbench for hmm_viterbi_decoder_core: directed items, one full-length
// sequence and random decode runs, each checked against an in-bench Viterbi predictor.
// Depends on hvd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_hmm_viterbi_decoder_core;
	import hvd_pkg::*;

	localparam int NUM_STATES   = 8;
	localparam int MAX_STEPS    = 64;
	localparam int RANDOM_ITEMS = 310;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam score_t NEAR_FLOOR = 24'sh800001;

	typedef struct {
		item_t      it;
		bit         typed;
		logic [1:0] err;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	hmm_viterbi_decoder_core #(
		.NUM_STATES(NUM_STATES),
		.MAX_STEPS (MAX_STEPS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #2 clk = ~clk;

	// Predictor state.
	score_t      trans_tbl [NUM_STATES][NUM_STATES];
	score_t      prev_sc [NUM_STATES];
	score_t      cur_sc [NUM_STATES];
	logic [2:0]  back_ptr [MAX_STEPS][NUM_STATES];
	int unsigned steps_done;
	int unsigned emit_state;
	result_t     decoded_q [$];
	stim_row_t   stim_rows [$];

	int mismatches;
	int items_fed;
	int results_seen;
	int paths_traced;
	int err_seen [4];
	int idle_cycles;
	int tx_rate;
	bit quiet;

	function automatic score_t add_sat(score_t a, score_t b);
		int s;
		if (a == SCORE_FLOOR || b == SCORE_FLOOR) begin
			return SCORE_FLOOR;
		end
		s = int'(a) + int'(b);
		if (s < -8388608) begin
			return SCORE_FLOOR;
		end
		if (s > 8388607) begin
			return SCORE_CEIL;
		end
		return score_t'(s);
	endfunction

	function automatic void restart_path();
		for (int i = 0; i < NUM_STATES; i++) begin
			prev_sc[i] = SCORE_FLOOR;
			cur_sc[i] = SCORE_FLOOR;
		end
		prev_sc[0] = '0;
		steps_done = 0;
		emit_state = 0;
	endfunction

	function automatic void push_result(logic [2:0] st, logic [5:0] t, score_t sc, logic last,
			logic [1:0] err);
		result_t r;
		r.state_index = st;
		r.time_index = t;
		r.best_score = sc;
		r.last = last;
		r.error_code = err;
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	function automatic void add_row(stim_row_t r);
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	function automatic void viterbi_step(item_t it);
		score_t     best;
		score_t     cand;
		logic [2:0] ptr;
		logic [2:0] st;
		case (it.command)
			CMD_LOAD: begin
				trans_tbl[it.from_state][it.to_state] = it.log_value;
			end
			CMD_EMIT: begin
				if (steps_done >= MAX_STEPS) begin
					push_result('0, '0, '0, 1'b1, ERR_FULL);
				end else if (it.to_state != emit_state) begin
					push_result('0, '0, '0, 1'b1, ERR_ORDER);
				end else begin
					best = SCORE_FLOOR;
					ptr = '0;
					for (int i = 0; i < NUM_STATES; i++) begin
						cand = add_sat(prev_sc[i], trans_tbl[i][it.to_state]);
						if (cand > best) begin
							best = cand;
							ptr = 3'(i);
						end
					end
					cur_sc[it.to_state] = add_sat(best, it.log_value);
					back_ptr[steps_done][it.to_state] = ptr;
					emit_state++;
					if (emit_state == NUM_STATES) begin
						prev_sc = cur_sc;
						for (int i = 0; i < NUM_STATES; i++) begin
							cur_sc[i] = SCORE_FLOOR;
						end
						emit_state = 0;
						steps_done++;
					end
				end
			end
			CMD_FINISH: begin
				if (steps_done == 0) begin
					push_result('0, '0, '0, 1'b1, ERR_EMPTY);
				end else begin
					best = SCORE_FLOOR;
					st = '0;
					for (int i = 0; i < NUM_STATES; i++) begin
						if (prev_sc[i] > best) begin
							best = prev_sc[i];
							st = 3'(i);
						end
					end
					// Walk the backpointers from the last step down to step 0.
					for (int t = int'(steps_done) - 1; t >= 0; t--) begin
						push_result(st, 6'(t), best, t == 0, ERR_OK);
						if (t > 0) begin
							st = back_ptr[t][st];
						end
					end
				end
				restart_path();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic item_t mk(logic [1:0] cmd, logic [2:0] src, logic [2:0] dst, score_t v);
		item_t x;
		x.command = cmd;
		x.from_state = src;
		x.to_state = dst;
		x.log_value = v;
		return x;
	endfunction

	function automatic stim_row_t stim_row(logic [1:0] cmd, logic [2:0] src, logic [2:0] dst,
			score_t v, bit typed = 1'b0, logic [1:0] err = ERR_OK);
		stim_row_t r;
		r.it = mk(cmd, src, dst, v);
		r.typed = typed;
		r.err = err;
		return r;
	endfunction

	// Mostly moderate log values, with a share of coarse ones so that ties occur, plus floor, ceiling and raw values.
	function automatic score_t pick_log();
		int v;
		case ($urandom_range(0, 15))
			0: v = int'(SCORE_FLOOR);
			1: v = int'(SCORE_CEIL);
			2: v = int'($urandom);
			3, 4, 5: v = -int'($urandom_range(0, 4)) * 65536;
			default: v = int'($urandom_range(0, 8 * 65536)) - 6 * 65536;
		endcase
		return score_t'(v);
	endfunction

	function automatic score_t pick_coarse();
		if ($urandom_range(0, 7) == 0) begin
			return SCORE_FLOOR;
		end
		return score_t'(-int'($urandom_range(0, 4)) * 65536);
	endfunction

	task automatic report_error(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Presents one item and waits for it to be taken. Typed rows replace the predicted
	// result with the error result written in the stimulus table.
	task automatic send(item_t x, bit typed = 1'b0, logic [1:0] typed_err = ERR_OK);
		int n0;
		if (!quiet && tx_rate != 0 && $urandom_range(1, 8) <= tx_rate) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		n0 = decoded_q.size();
		viterbi_step(x);
		if (typed) begin
			while (decoded_q.size() > n0) void'(decoded_q.pop_back());
			push_result('0, '0, '0, 1'b1, typed_err);
		end
		if (x.command != CMD_UNUSED) begin
			items_fed++;
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic run_path();
		int nsteps;
		int partial;
		tx_rate = $urandom_range(0, 3);
		repeat ($urandom_range(0, 3)) begin
			send(mk(CMD_LOAD, 3'($urandom), 3'($urandom), pick_log()));
		end
		nsteps = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
		partial = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NUM_STATES - 1) : 0;
		for (int s = 0; s < nsteps; s++) begin
			for (int j = 0; j < NUM_STATES; j++) begin
				if ($urandom_range(0, 39) == 0) begin
					send(mk(CMD_EMIT, 3'($urandom), 3'(j) ^ 3'($urandom_range(1, 7)), pick_log()));
				end
				if ($urandom_range(0, 39) == 0) begin
					send(mk(CMD_UNUSED, 3'($urandom), 3'($urandom), score_t'($urandom)));
				end
				send(mk(CMD_EMIT, 3'($urandom), 3'(j), pick_log()));
			end
		end
		for (int j = 0; j < partial; j++) begin
			send(mk(CMD_EMIT, 3'($urandom), 3'(j), pick_log()));
		end
		send(mk(CMD_FINISH, 3'($urandom), 3'($urandom), score_t'($urandom)));
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			err_seen[result.error_code]++;
			if (result.last && result.error_code == ERR_OK) begin
				paths_traced++;
			end
			if (decoded_q.size() == 0) begin
				report_error($sformatf("unexpected result: state %0d step %0d error %0d",
					result.state_index, result.time_index, result.error_code));
			end else begin
				want = decoded_q.pop_front();
				if (result.state_index !== want.state_index)
					report_error($sformatf("state_index at step %0d: got %0d, want %0d",
						want.time_index, result.state_index, want.state_index));
				if (result.time_index !== want.time_index)
					report_error($sformatf("time_index: got %0d, want %0d",
						result.time_index, want.time_index));
				if (result.best_score !== want.best_score)
					report_error($sformatf("best_score at step %0d: got %0d, want %0d",
						want.time_index, result.best_score, want.best_score));
				if (result.last !== want.last)
					report_error($sformatf("last at step %0d: got %0b, want %0b",
						want.time_index, result.last, want.last));
				if (result.error_code !== want.error_code)
					report_error($sformatf("error_code: got %0d, want %0d",
						result.error_code, want.error_code));
			end
		end
	end

	// Result side stalls in bursts; the stall rate drifts over the run.
	initial begin
		int rx_rate;
		rx_rate = 2;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				rx_rate = $urandom_range(0, 4);
			end
			if (!quiet && rx_rate != 0 && $urandom_range(1, 8) <= rx_rate) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("No handshake for %0d cycles, %0d results outstanding",
					STALL_LIMIT, decoded_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int base;
		restart_path();
		tx_rate = 2;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every transition entry is written before the first emission reads a column.
		for (int i = 0; i < NUM_STATES; i++) begin
			for (int j = 0; j < NUM_STATES; j++) begin
				send(mk(CMD_LOAD, 3'(i), 3'(j), pick_coarse()));
			end
		end

		add_row(stim_row(CMD_FINISH, 3'd0, 3'd0, '0, 1'b1, ERR_EMPTY));
		add_row(stim_row(CMD_UNUSED, 3'd0, 3'd0, '0));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd4, '0, 1'b1, ERR_ORDER));
		add_row(stim_row(CMD_LOAD,   3'd0, 3'd5, SCORE_FLOOR));
		add_row(stim_row(CMD_LOAD,   3'd0, 3'd1, SCORE_CEIL));
		add_row(stim_row(CMD_LOAD,   3'd0, 3'd2, NEAR_FLOOR));
		add_row(stim_row(CMD_LOAD,   3'd7, 3'd7, SCORE_CEIL));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd0, -24'sd1));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd1, SCORE_CEIL));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd2, NEAR_FLOOR));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd3, '0));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd4, SCORE_FLOOR));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd5, 24'sd12345));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd6, -24'sd65536));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd7, 24'sd65536));
		add_row(stim_row(CMD_EMIT,   3'd7, 3'd0, -24'sd1));
		add_row(stim_row(CMD_EMIT,   3'd0, 3'd2, '0, 1'b1, ERR_ORDER));
		add_row(stim_row(CMD_FINISH, 3'd0, 3'd0, '0));
		add_row(stim_row(CMD_FINISH, 3'd7, 3'd7, -24'sd1, 1'b1, ERR_EMPTY));
		add_row(stim_row(CMD_UNUSED, 3'd7, 3'd7, -24'sd1));
		foreach (stim_rows[k]) begin
			send(stim_rows[k].it, stim_rows[k].typed, stim_rows[k].err);
		end
		drain_results();

		// Fill every time step, then knock on the full sequence, in and out of order.
		tx_rate = 1;
		for (int s = 0; s < MAX_STEPS; s++) begin
			for (int j = 0; j < NUM_STATES; j++) begin
				send(mk(CMD_EMIT, 3'($urandom), 3'(j), pick_log()));
			end
		end
		send(mk(CMD_EMIT, 3'd0, 3'd0, pick_log()));
		send(mk(CMD_EMIT, 3'd0, 3'd5, pick_log()));
		send(mk(CMD_FINISH, 3'($urandom), 3'($urandom), score_t'($urandom)));
		drain_results();

		base = items_fed;
		while (items_fed < base + RANDOM_ITEMS) begin
			quiet = (items_fed + 60 >= base + RANDOM_ITEMS);
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 2))
						0: send(mk(CMD_UNUSED, 3'($urandom), 3'($urandom), score_t'($urandom)));
						1: send(mk(CMD_EMIT, 3'($urandom), 3'($urandom_range(1, 7)), pick_log()));
						default: send(mk(CMD_FINISH, 3'($urandom), 3'($urandom),
							score_t'($urandom)));
					endcase
				end
				1: begin
					run_path();
					drain_results();
				end
				default: run_path();
			endcase
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0) begin
			report_error($sformatf("%0d decoded results never arrived", decoded_q.size()));
		end

		$display("Run covered %0d items incl. one %0d-step sequence, %0d results, %0d paths.",
			items_fed, MAX_STEPS, results_seen, paths_traced);
		$display("Error results: out of order %0d, sequence full %0d, empty sequence %0d.",
			err_seen[ERR_ORDER], err_seen[ERR_FULL], err_seen[ERR_EMPTY]);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/hvd_pkg.sv
hdl/hvd_ram.sv
hdl/hvd_acs.sv
hdl/hmm_viterbi_decoder_core.sv
hdl/hvd_checker.sv
tb/tb_hmm_viterbi_decoder_core.sv
